>>> hdl/brf_pkg.sv
package brf_pkg;

    localparam int FILL_W = 6;

    typedef enum logic [1:0] {
        MODE_WRITE   = 2'd0,
        MODE_PEEK    = 2'd1,
        MODE_CONSUME = 2'd2,
        MODE_SPARE   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_WRITTEN  = 2'd0,
        ST_REJECTED = 2'd1,
        ST_READ     = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] data_in;
    } t_in_beat;

    typedef struct packed {
        logic [7:0]        data_out;
        logic [1:0]        status;
        logic              last;
        logic [FILL_W-1:0] fill_level;
    } t_out_beat;

endpackage

>>> hdl/brf_ram.sv
module brf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/brf_ctrl.sv
module brf_ctrl #(
    parameter int DEPTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  brf_pkg::t_in_beat i_in,
    output logic              o_in_stall,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_data,
    output logic              o_cfg_ready,
    input  logic              i_out_free,
    output logic              o_emit_valid,
    output brf_pkg::t_out_beat o_emit
);
    import brf_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RDOUT
    } t_state;

    t_state          r_state, n_state;
    logic [1:0]      r_mode, n_mode;
    logic [7:0]      r_data, n_data;
    logic [AW-1:0]   r_wp, n_wp;
    logic [AW-1:0]   r_rp, n_rp;
    logic [AW-1:0]   r_p, n_p;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [CW-1:0]   r_left, n_left;
    logic            r_ovw, n_ovw;

    logic            ram_we;
    logic            ram_re;
    logic [AW-1:0]   ram_raddr;
    logic [7:0]      ram_rdata;
    logic            full;
    logic            consume;
    logic            is_last;

    function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    brf_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wp),
        .i_wdata (r_data),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign full        = (r_cnt == CW'(DEPTH));
    assign consume     = r_mode[1];
    assign is_last     = (r_left == CW'(1));
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_data       = r_data;
        n_wp         = r_wp;
        n_rp         = r_rp;
        n_p          = r_p;
        n_cnt        = r_cnt;
        n_left       = r_left;
        n_ovw        = r_ovw;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_raddr    = r_rp;
        o_emit_valid = 1'b0;
        o_emit       = '0;

        if (i_cfg_valid && o_cfg_ready) begin
            n_ovw = i_cfg_data;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_mode  = i_in.mode;
                    n_data  = i_in.data_in;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_mode == MODE_WRITE) begin
                    if (i_out_free) begin
                        o_emit_valid = 1'b1;
                        o_emit.last  = 1'b1;
                        if (full && !r_ovw) begin
                            o_emit.status     = ST_REJECTED;
                            o_emit.fill_level = FILL_W'(r_cnt);
                        end else begin
                            ram_we = 1'b1;
                            n_wp   = next_ptr(r_wp);
                            o_emit.status = ST_WRITTEN;
                            if (full) begin
                                n_rp = next_ptr(r_rp);
                                o_emit.fill_level = FILL_W'(r_cnt);
                            end else begin
                                n_cnt = r_cnt + CW'(1);
                                o_emit.fill_level = FILL_W'(r_cnt + CW'(1));
                            end
                        end
                        n_state = S_IDLE;
                    end
                end else if (r_cnt == '0) begin
                    if (i_out_free) begin
                        o_emit_valid  = 1'b1;
                        o_emit.status = ST_EMPTY;
                        o_emit.last   = 1'b1;
                        n_state       = S_IDLE;
                    end
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = r_rp;
                    n_p       = r_rp;
                    n_left    = r_cnt;
                    n_state   = S_RDOUT;
                end
            end
            S_RDOUT: begin
                if (i_out_free) begin
                    o_emit_valid      = 1'b1;
                    o_emit.data_out   = ram_rdata;
                    o_emit.status     = ST_READ;
                    o_emit.last       = is_last;
                    o_emit.fill_level = consume ? '0 : FILL_W'(r_cnt);
                    if (is_last) begin
                        if (consume) begin
                            n_rp  = r_wp;
                            n_cnt = '0;
                        end
                        n_state = S_IDLE;
                    end else begin
                        n_p       = next_ptr(r_p);
                        ram_re    = 1'b1;
                        ram_raddr = next_ptr(r_p);
                        n_left    = r_left - CW'(1);
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wp    <= '0;
            r_rp    <= '0;
            r_cnt   <= '0;
            r_ovw   <= 1'b1;
            r_left  <= '0;
        end else begin
            r_state <= n_state;
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_cnt   <= n_cnt;
            r_ovw   <= n_ovw;
            r_left  <= n_left;
        end
        r_mode <= n_mode;
        r_data <= n_data;
        r_p    <= n_p;
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("fill count above depth");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0 || r_cnt == CW'(DEPTH)) |-> (r_wp == r_rp))
        else $error("pointers disagree with fill count");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit_valid |-> i_out_free)
        else $error("beat emitted into a busy output register");

    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RDOUT) |-> (r_left != '0))
        else $error("drain with nothing left");

    a_drain_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RDOUT && !i_out_free) |=> (r_state == S_RDOUT && $stable(r_left)))
        else $error("drain advanced while output held");
`endif

endmodule

>>> hdl/byte_ring_fifo_overwrite_top.sv
// Circular byte FIFO with optional overwrite of the oldest byte.
// Input channel (i_in_valid / o_in_stall / i_in): one beat per item. Mode write
// stores data_in; a full FIFO either drops its oldest byte (overwrite enabled)
// or rejects the byte. Modes peek and consume emit every unread byte, oldest
// first, last set on the final beat; consume then empties the FIFO, and the
// spare mode acts as consume. A read of an empty FIFO yields one beat with
// status empty. Every beat carries the fill level after the item.
// Output channel (o_out_valid / i_out_stall / o_out): one registered beat; a
// stalled beat holds until taken and the sequencer waits for it.
// Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data): overwrite enable,
// taken while no item is in progress.
// Sequence: an item is accepted in the idle state and registered; it executes in
// the execute state, which puts the beat of a write or an empty read into the
// output register. A read fetches its first byte there and emits its bytes from
// the drain state, one byte per cycle while the output is not stalled, out of
// the single read port of the byte store. A new item waits until the last is done.
// Reset: synchronous, active low; clears pointers and fill count, sets
// overwrite enable, drops any pending output beat. Store contents persist.
module byte_ring_fifo_overwrite_top #(
    parameter int DEPTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  brf_pkg::t_in_beat  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output brf_pkg::t_out_beat o_out,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_data
);
    import brf_pkg::*;

    logic      r_out_valid;
    t_out_beat r_out;
    logic      out_free;
    logic      emit_valid;
    t_out_beat emit;

    assign out_free = !r_out_valid || !i_out_stall;

    brf_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in         (i_in),
        .o_in_stall   (o_in_stall),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .o_cfg_ready  (o_cfg_ready),
        .i_out_free   (out_free),
        .o_emit_valid (emit_valid),
        .o_emit       (emit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= emit_valid;
        end
        if (out_free && emit_valid) begin
            r_out <= emit;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

>>> tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import brf_pkg::*;

    localparam int FIFO_DEPTH  = 32;
    localparam int CYCLE_LIMIT = 1_000_000;

    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_FILL,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        t_row_kind  kind;
        logic [1:0] mode;
        logic [7:0] data;
        logic [5:0] reps;
        logic       has_want;
        t_out_beat  want;
    } t_row;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_beat  in_beat = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_beat out_beat;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic      cfg_data = 1'b0;

    // typed expectation riding along with the current input beat
    logic      want_on = 1'b0;
    t_out_beat want_beat = '0;

    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    bit hold_go = 1'b0;
    int hold_left = 0;
    int n_err = 0;
    int cycles = 0;

    // shadow copy of the FIFO
    logic [7:0] shadow_mem [FIFO_DEPTH];
    logic [4:0] shadow_wr = '0;
    logic [4:0] shadow_rd = '0;
    logic [5:0] shadow_cnt = '0;
    logic       shadow_ow = 1'b1;

    t_out_beat due_beats [$];

    t_row dir_rows [21] = '{
        '{ROW_ITEM, MODE_PEEK,    8'h00, 6'd1,  1'b1, '{8'h00, ST_EMPTY,    1'b1, 6'd0}},
        '{ROW_ITEM, MODE_CONSUME, 8'hFF, 6'd1,  1'b1, '{8'h00, ST_EMPTY,    1'b1, 6'd0}},
        '{ROW_ITEM, MODE_SPARE,   8'h55, 6'd1,  1'b1, '{8'h00, ST_EMPTY,    1'b1, 6'd0}},
        '{ROW_ITEM, MODE_WRITE,   8'h00, 6'd1,  1'b1, '{8'h00, ST_WRITTEN,  1'b1, 6'd1}},
        '{ROW_ITEM, MODE_WRITE,   8'hFF, 6'd1,  1'b1, '{8'h00, ST_WRITTEN,  1'b1, 6'd2}},
        '{ROW_ITEM, MODE_PEEK,    8'h00, 6'd1,  1'b0, '0},
        '{ROW_ITEM, MODE_SPARE,   8'h00, 6'd1,  1'b0, '0},
        '{ROW_ITEM, MODE_PEEK,    8'hAA, 6'd1,  1'b1, '{8'h00, ST_EMPTY,    1'b1, 6'd0}},
        '{ROW_FILL, MODE_WRITE,   8'h00, 6'd31, 1'b0, '0},
        '{ROW_ITEM, MODE_WRITE,   8'hA5, 6'd1,  1'b1, '{8'h00, ST_WRITTEN,  1'b1, 6'd32}},
        '{ROW_ITEM, MODE_WRITE,   8'h5A, 6'd1,  1'b1, '{8'h00, ST_WRITTEN,  1'b1, 6'd32}},
        '{ROW_ITEM, MODE_PEEK,    8'h00, 6'd1,  1'b0, '0},
        '{ROW_CFG,  MODE_WRITE,   8'h00, 6'd1,  1'b0, '0},
        '{ROW_ITEM, MODE_WRITE,   8'h3C, 6'd1,  1'b1, '{8'h00, ST_REJECTED, 1'b1, 6'd32}},
        '{ROW_ITEM, MODE_PEEK,    8'h00, 6'd1,  1'b0, '0},
        '{ROW_ITEM, MODE_CONSUME, 8'h00, 6'd1,  1'b0, '0},
        '{ROW_FILL, MODE_WRITE,   8'h00, 6'd32, 1'b0, '0},
        '{ROW_ITEM, MODE_WRITE,   8'hC3, 6'd1,  1'b1, '{8'h00, ST_REJECTED, 1'b1, 6'd32}},
        '{ROW_ITEM, MODE_CONSUME, 8'h00, 6'd1,  1'b0, '0},
        '{ROW_CFG,  MODE_WRITE,   8'h01, 6'd1,  1'b0, '0},
        '{ROW_ITEM, MODE_CONSUME, 8'h00, 6'd1,  1'b1, '{8'h00, ST_EMPTY,    1'b1, 6'd0}}
    };

    byte_ring_fifo_overwrite_top #(
        .DEPTH(FIFO_DEPTH)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in       (in_beat),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out      (out_beat),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    function automatic t_in_beat make_beat(input logic [1:0] mode, input logic [7:0] data);
        t_in_beat b;
        b.mode    = mode;
        b.data_in = data;
        return b;
    endfunction

    function automatic void predict_fifo_item(input t_in_beat b);
        t_out_beat  r;
        logic [4:0] p;
        logic [5:0] n;
        logic [5:0] fill;
        r = '0;
        r.last = 1'b1;
        if (b.mode == MODE_WRITE) begin
            r.status = ST_WRITTEN;
            if (shadow_cnt >= FIFO_DEPTH) begin
                if (shadow_ow) begin
                    shadow_mem[shadow_wr] = b.data_in;
                    shadow_wr = shadow_wr + 5'd1;
                    shadow_rd = shadow_rd + 5'd1;
                end else begin
                    r.status = ST_REJECTED;
                end
            end else begin
                shadow_mem[shadow_wr] = b.data_in;
                shadow_wr = shadow_wr + 5'd1;
                shadow_cnt = shadow_cnt + 6'd1;
            end
            r.fill_level = shadow_cnt;
            due_beats.push_back(r);
        end else if (shadow_cnt == 0) begin
            r.status = ST_EMPTY;
            due_beats.push_back(r);
        end else begin
            // mode bit 1 selects consume, so the spare code drains too
            n = shadow_cnt;
            fill = b.mode[1] ? 6'd0 : n;
            p = shadow_rd;
            for (int k = 0; k < n; k++) begin
                r.data_out   = shadow_mem[p];
                r.status     = ST_READ;
                r.last       = (k == n - 1);
                r.fill_level = fill;
                due_beats.push_back(r);
                p = p + 5'd1;
            end
            if (b.mode[1]) begin
                shadow_rd = shadow_wr;
                shadow_cnt = '0;
            end
        end
    endfunction

    always @(posedge clk) begin
        t_out_beat e;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (due_beats.size() == 0) begin
                    $error("unexpected output beat %h", out_beat);
                    n_err++;
                end else begin
                    e = due_beats.pop_front();
                    if (out_beat.data_out !== e.data_out) begin
                        $error("data_out exp %0h got %0h", e.data_out, out_beat.data_out);
                        n_err++;
                    end
                    if (out_beat.status !== e.status) begin
                        $error("status exp %0d got %0d", e.status, out_beat.status);
                        n_err++;
                    end
                    if (out_beat.last !== e.last) begin
                        $error("last exp %0d got %0d", e.last, out_beat.last);
                        n_err++;
                    end
                    if (out_beat.fill_level !== e.fill_level) begin
                        $error("fill_level exp %0d got %0d", e.fill_level,
                               out_beat.fill_level);
                        n_err++;
                    end
                end
            end
            if (in_valid && !in_stall) begin
                predict_fifo_item(in_beat);
                if (want_on) begin
                    void'(due_beats.pop_back());
                    due_beats.push_back(want_beat);
                end
            end
        end
    end

    always @(negedge clk) begin
        if (hold_go) begin
            hold_left = 300;
            hold_go = 1'b0;
        end
        if (hold_left > 0)
            hold_left--;
        out_stall <= (hold_left > 0) || ($urandom_range(99) < sink_stall_pct);
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_beat(input t_in_beat b, input logic has_want, input t_out_beat want);
        while ($urandom_range(99) < src_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        in_beat   <= b;
        want_on   <= has_want;
        want_beat <= want;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (due_beats.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_cfg(input logic ow);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= ow;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        shadow_ow = ow;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int n_items);
        int         left;
        int         burst;
        int         pick;
        logic [1:0] rmode;
        left = n_items;
        while (left > 0) begin
            // write bursts, sometimes long enough to hit full
            burst = ($urandom_range(2) == 0) ? $urandom_range(36) : $urandom_range(5);
            for (int i = 0; i < burst && left > 0; i++) begin
                send_beat(make_beat(MODE_WRITE, 8'($urandom_range(255))), 1'b0, '0);
                left--;
            end
            if (left > 0) begin
                pick = $urandom_range(9);
                rmode = (pick < 4) ? MODE_PEEK :
                        (pick < 8) ? MODE_CONSUME :
                        (pick == 8) ? MODE_SPARE : 2'($urandom_range(3));
                send_beat(make_beat(rmode, 8'($urandom_range(255))), 1'b0, '0);
                left--;
            end
        end
    endtask

    initial begin
        rst_n <= 1'b0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i]) begin
            case (dir_rows[i].kind)
                ROW_CFG: begin
                    write_cfg(dir_rows[i].data[0]);
                end
                ROW_FILL: begin
                    repeat (dir_rows[i].reps)
                        send_beat(make_beat(MODE_WRITE, 8'($urandom_range(255))), 1'b0, '0);
                end
                default: begin
                    send_beat(make_beat(dir_rows[i].mode, dir_rows[i].data),
                              dir_rows[i].has_want, dir_rows[i].want);
                end
            endcase
        end

        run_random(35);

        write_cfg(1'b0);
        src_idle_pct = 88;
        run_random(30);

        write_cfg(1'b1);
        src_idle_pct = 0;
        sink_stall_pct = 88;
        run_random(30);

        write_cfg(1'b0);
        src_idle_pct = 7;
        sink_stall_pct = 7;
        run_random(30);

        // long receiver hold-off while beats keep coming
        write_cfg(1'b1);
        src_idle_pct = 0;
        sink_stall_pct = 0;
        hold_go = 1'b1;
        run_random(15);

        // sender pauses until everything is out
        drain();
        src_idle_pct = 7;
        sink_stall_pct = 7;
        run_random(10);

        drain();
        repeat (16) @(negedge clk);
        if (n_err == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> files.f
hdl/brf_pkg.sv
hdl/brf_ram.sv
hdl/brf_ctrl.sv
hdl/byte_ring_fifo_overwrite_top.sv
tb/tb.sv
